// File: rtl/core/tblp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tblp_pkg
// Shared constants, widths and helpers of the tile/bin layout planner.
// ----------------------------------------------------------------------------
package tblp_pkg;

    // Layer stride alignment and pipe grid limits
    localparam int STRIDE_ALIGN_LOG2 = 12;
    localparam int PIPE_TILE_MAX     = 32;
    localparam int MERGE_PIPE_W      = 4;
    localparam int MERGE_PIPE_H      = 8;

    // Datapath widths
    localparam int DW   = 26;                       // shared divider width
    localparam int CW   = $clog2(DW);               // divider step counter
    localparam int AHW  = 11 + STRIDE_ALIGN_LOG2;   // widened height granularity
    localparam int MW   = 16;                       // multiplier operand width
    localparam int SHW  = $clog2(STRIDE_ALIGN_LOG2 + 1);

    // Configuration register indexes
    localparam logic [2:0] REG_ALIGN_W   = 3'd0;
    localparam logic [2:0] REG_ALIGN_H   = 3'd1;
    localparam logic [2:0] REG_MAX_TW    = 3'd2;
    localparam logic [2:0] REG_MAX_TH    = 3'd3;
    localparam logic [2:0] REG_PIPE_LIM  = 3'd4;
    localparam logic [2:0] REG_FORCE     = 3'd5;
    localparam logic [2:0] REG_DISABLE   = 3'd6;
    localparam logic [2:0] REG_MERGE     = 3'd7;

    // Trailing zero count of an 11-bit value (value is nonzero)
    function automatic logic [3:0] tz11(input logic [10:0] v);
        logic [3:0] t;
        t = 4'd0;
        for (int i = 10; i >= 0; i--) begin
            if (v[i]) t = 4'(i);
        end
        return t;
    endfunction

    // Trailing zero count of a 7-bit value (value is nonzero)
    function automatic logic [2:0] tz7(input logic [6:0] v);
        logic [2:0] t;
        t = 3'd0;
        for (int i = 6; i >= 0; i--) begin
            if (v[i]) t = 3'(i);
        end
        return t;
    endfunction

endpackage

// File: rtl/core/tile_bin_layout_planner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_bin_layout_planner
// Plans tile size, tile counts and pipe grid for one framebuffer request.
// ----------------------------------------------------------------------------
// Channel    Direction  Handshake                   Payload
// request    in         start & !busy               i_frame_* .. i_density_map
// result     out        o_done (one-cycle strobe)   o_possible .. o_binning_on
// config     in         i_cfg_valid & o_cfg_ready   i_cfg_index, i_cfg_data
//
// One item runs through a small sequencer around a shared restoring divider
// and a registered 16x16 multiplier, each launched from an issuing state.
// An item tries each aligned width up to the maximum; a width with a nonzero
// height does more work than one that gives none, and force mode and each
// pipe grid growth step add work. A zero budget raises o_done in the cycle
// after acceptance.
// busy is high from the cycle after acceptance through the o_done cycle.
// Reset is synchronous; config is always ready. The receiver cannot stall.
// ----------------------------------------------------------------------------
module tile_bin_layout_planner
    import tblp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [14:0] i_frame_width,
    input  logic [14:0] i_frame_height,
    input  logic [11:0] i_frame_layers,
    input  logic [5:0]  i_view_count,
    input  logic [6:0]  i_min_bytes_per_pixel,
    input  logic [23:0] i_budget_pixels,
    input  logic        i_density_map,
    output logic        o_done,
    output logic        o_possible,
    output logic [12:0] o_tile_width,
    output logic [12:0] o_tile_height,
    output logic [14:0] o_tiles_x,
    output logic [14:0] o_tiles_y,
    output logic [14:0] o_pipe_tiles_x,
    output logic [14:0] o_pipe_tiles_y,
    output logic [14:0] o_pipes_x,
    output logic [14:0] o_pipes_y,
    output logic        o_binning_ok,
    output logic        o_binning_on,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    // Sequencer codes
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DIV   = 5'd1;
    localparam logic [4:0] S_MUL   = 5'd2;
    localparam logic [4:0] S_MAXW  = 5'd3;
    localparam logic [4:0] S_MAXH  = 5'd4;
    localparam logic [4:0] S_WCHK  = 5'd5;
    localparam logic [4:0] S_WMUL  = 5'd6;
    localparam logic [4:0] S_H1    = 5'd7;
    localparam logic [4:0] S_H2    = 5'd8;
    localparam logic [4:0] S_CX    = 5'd9;
    localparam logic [4:0] S_CY    = 5'd10;
    localparam logic [4:0] S_H3    = 5'd11;
    localparam logic [4:0] S_H4    = 5'd12;
    localparam logic [4:0] S_CMP   = 5'd13;
    localparam logic [4:0] S_WNEXT = 5'd14;
    localparam logic [4:0] S_FORCE = 5'd15;
    localparam logic [4:0] S_FX    = 5'd16;
    localparam logic [4:0] S_FY    = 5'd17;
    localparam logic [4:0] S_FY2   = 5'd18;
    localparam logic [4:0] S_PIPE  = 5'd19;
    localparam logic [4:0] S_MOK   = 5'd22;
    localparam logic [4:0] S_GCHK  = 5'd23;
    localparam logic [4:0] S_GX    = 5'd24;
    localparam logic [4:0] S_GY    = 5'd25;
    localparam logic [4:0] S_GOK   = 5'd26;
    localparam logic [4:0] S_ON    = 5'd27;
    localparam logic [4:0] S_ON2   = 5'd28;
    localparam logic [4:0] S_DONE  = 5'd29;

    // Configuration registers
    logic [10:0] r_cfg_aw, r_cfg_ah;
    logic [12:0] r_cfg_mtw, r_cfg_mth;
    logic [5:0]  r_cfg_lim;
    logic        r_cfg_force, r_cfg_dis, r_cfg_merge;

    // Control state
    logic [4:0]  r_state, n_state, r_ret, n_ret;
    logic [CW-1:0] r_cnt, n_cnt;

    // Item payload and working registers
    logic [14:0] r_fw, n_fw, r_fh, n_fh;
    logic [11:0] r_layers, n_layers;
    logic [23:0] r_budget, n_budget;
    logic        r_fdm, n_fdm;
    logic [10:0] r_aw, n_aw;
    logic [AHW-1:0] r_ah, n_ah;
    logic [5:0]  r_limit, n_limit;
    logic [13:0] r_maxw, n_maxw, r_w, n_w, r_tw, n_tw;
    logic [12:0] r_maxh, n_maxh, r_h, n_h;
    logic [AHW-1:0] r_hc, n_hc, r_th, n_th, r_bdiff, n_bdiff;
    logic [14:0] r_cx, n_cx, r_cy, n_cy, r_tcx, n_tcx, r_tcy, n_tcy;
    logic [29:0] r_best, n_best;
    logic        r_found, n_found, r_ok, n_ok, r_on, n_on;
    logic [14:0] r_pw, n_pw, r_ph, n_ph, r_pcx, n_pcx, r_pcy, n_pcy;

    // Shared divider and multiplier
    logic [DW-1:0] r_dvd, n_dvd, r_dvs, n_dvs, r_quo, n_quo, r_rem, n_rem;
    logic [MW-1:0] r_ma, n_ma, r_mb, n_mb;
    logic [2*MW-1:0] r_prod;

    logic          div_go, mul_go;
    logic [DW-1:0] div_a, div_b;
    logic [MW-1:0] mul_a, mul_b;
    logic [4:0]    go_ret;

    logic [DW:0]   rem_sh, rem_sub;
    logic [DW-1:0] q_ceil, q_rup;
    logic [10:0]   aw_in, ah_in;
    logic [11:0]   lay_max;
    logic [4:0]    tz_sum;
    logic [SHW-1:0] ah_sh;
    logic [AHW-1:0] cand_diff;
    logic [AHW-1:0] w_ext;
    logic [14:0]   m_pcx, m_pcy;
    logic           item_acc;

    assign item_acc    = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Divider results
    assign rem_sh  = {r_rem, r_quo[DW-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign q_ceil  = r_quo + DW'(r_rem != '0);
    assign q_rup   = r_dvd + ((r_rem != '0) ? (r_dvs - r_rem) : '0);

    // Request decode: zero fixes and stride alignment of the height granularity
    assign aw_in   = (r_cfg_aw == '0) ? 11'd1 : r_cfg_aw;
    assign ah_in   = (r_cfg_ah == '0) ? 11'd1 : r_cfg_ah;
    assign lay_max = (i_frame_layers > {6'd0, i_view_count}) ? i_frame_layers
                                                             : {6'd0, i_view_count};
    assign tz_sum  = 5'(tz11(aw_in)) + 5'(tz11(ah_in)) + 5'(tz7(i_min_bytes_per_pixel));
    assign ah_sh   = (lay_max > 12'd1 && i_min_bytes_per_pixel != '0 &&
                      tz_sum < 5'(STRIDE_ALIGN_LOG2))
                     ? SHW'(5'(STRIDE_ALIGN_LOG2) - tz_sum) : '0;

    // Candidate squareness
    assign w_ext     = AHW'(r_w);
    assign cand_diff = (w_ext > r_hc) ? (w_ext - r_hc) : (r_hc - w_ext);

    // Merged grid: fixed pipe size, pipe counts rounded up from the tile counts
    assign m_pcx = 15'((16'(r_tcx) + 16'(MERGE_PIPE_W - 1)) / 16'(MERGE_PIPE_W));
    assign m_pcy = 15'((16'(r_tcy) + 16'(MERGE_PIPE_H - 1)) / 16'(MERGE_PIPE_H));

    // Sequencer
    always_comb begin
        n_state = r_state;  n_ret = r_ret;  n_cnt = r_cnt;
        n_fw = r_fw;  n_fh = r_fh;  n_layers = r_layers;  n_budget = r_budget;
        n_fdm = r_fdm;  n_aw = r_aw;  n_ah = r_ah;  n_limit = r_limit;
        n_maxw = r_maxw;  n_maxh = r_maxh;  n_w = r_w;  n_h = r_h;  n_hc = r_hc;
        n_cx = r_cx;  n_cy = r_cy;  n_tw = r_tw;  n_th = r_th;
        n_tcx = r_tcx;  n_tcy = r_tcy;  n_best = r_best;  n_bdiff = r_bdiff;
        n_found = r_found;  n_ok = r_ok;  n_on = r_on;
        n_pw = r_pw;  n_ph = r_ph;  n_pcx = r_pcx;  n_pcy = r_pcy;
        n_dvd = r_dvd;  n_dvs = r_dvs;  n_quo = r_quo;  n_rem = r_rem;
        n_ma = r_ma;  n_mb = r_mb;
        div_go = 1'b0;  mul_go = 1'b0;
        div_a = '0;  div_b = '0;  mul_a = '0;  mul_b = '0;  go_ret = S_IDLE;

        case (r_state)
            S_IDLE: begin
                if (item_acc) begin
                    n_fw = i_frame_width;  n_fh = i_frame_height;
                    n_layers = (lay_max == '0) ? 12'd1 : lay_max;
                    n_budget = i_budget_pixels;  n_fdm = i_density_map;
                    n_aw = aw_in;
                    n_ah = AHW'(ah_in) << ah_sh;
                    n_limit = (r_cfg_lim == '0) ? 6'd1 : r_cfg_lim;
                    n_tw = '0;  n_th = '0;  n_tcx = 15'd1;  n_tcy = 15'd1;
                    n_pw = 15'd1;  n_ph = 15'd1;  n_pcx = 15'd1;  n_pcy = 15'd1;
                    n_found = 1'b0;  n_ok = 1'b0;  n_on = 1'b0;
                    if (i_budget_pixels == '0) begin
                        n_state = S_DONE;
                    end else begin
                        div_go = 1'b1;  div_a = DW'(i_frame_width);
                        div_b = DW'(aw_in);  go_ret = S_MAXW;
                    end
                end
            end
            // one restoring step a cycle
            S_DIV: begin
                if (!rem_sub[DW]) begin
                    n_rem = rem_sub[DW-1:0];
                    n_quo = {r_quo[DW-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[DW-1:0];
                    n_quo = {r_quo[DW-2:0], 1'b0};
                end
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(DW - 1)) n_state = r_ret;
            end
            // product registers during this cycle
            S_MUL: begin
                n_state = r_ret;
            end
            S_MAXW: begin
                n_maxw = (q_rup < DW'(r_cfg_mtw)) ? q_rup[13:0] : 14'(r_cfg_mtw);
                div_go = 1'b1;  div_a = DW'(r_fh);  div_b = DW'(r_ah);  go_ret = S_MAXH;
            end
            S_MAXH: begin
                n_maxh = (q_rup < DW'(r_cfg_mth)) ? q_rup[12:0] : r_cfg_mth;
                n_w = 14'(r_aw);
                n_state = S_WCHK;
            end
            // width loop
            S_WCHK: begin
                if (r_w > r_maxw) begin
                    n_state = S_FORCE;
                end else begin
                    mul_go = 1'b1;  mul_a = MW'(r_w);  mul_b = MW'(r_layers);
                    go_ret = S_WMUL;
                end
            end
            S_WMUL: begin
                div_go = 1'b1;  div_a = DW'(r_budget);  div_b = r_prod[DW-1:0];
                go_ret = S_H1;
            end
            S_H1: begin
                n_h = (r_quo < DW'(r_maxh)) ? r_quo[12:0] : r_maxh;
                div_go = 1'b1;
                div_a = (r_quo < DW'(r_maxh)) ? r_quo : DW'(r_maxh);
                div_b = DW'(r_ah);  go_ret = S_H2;
            end
            S_H2: begin
                n_h = 13'(r_dvd - r_rem);
                if (r_dvd == r_rem) begin
                    n_state = S_WNEXT;
                end else begin
                    div_go = 1'b1;  div_a = DW'(r_fw);  div_b = DW'(r_w);  go_ret = S_CX;
                end
            end
            S_CX: begin
                n_cx = q_ceil[14:0];
                div_go = 1'b1;  div_a = DW'(r_fh);  div_b = DW'(r_h);  go_ret = S_CY;
            end
            S_CY: begin
                n_cy = q_ceil[14:0];
                div_go = 1'b1;  div_a = DW'(r_fh);  div_b = q_ceil;  go_ret = S_H3;
            end
            S_H3: begin
                div_go = 1'b1;  div_a = q_ceil;  div_b = DW'(r_ah);  go_ret = S_H4;
            end
            S_H4: begin
                n_hc = q_rup[AHW-1:0];
                mul_go = 1'b1;  mul_a = MW'(r_cx);  mul_b = MW'(r_cy);  go_ret = S_CMP;
            end
            // fewest bins, then squarest tile
            S_CMP: begin
                if (!r_found || r_prod[29:0] < r_best ||
                    (r_prod[29:0] == r_best && cand_diff < r_bdiff)) begin
                    n_found = 1'b1;
                    n_tw = r_w;  n_th = r_hc;  n_tcx = r_cx;  n_tcy = r_cy;
                    n_best = r_prod[29:0];  n_bdiff = cand_diff;
                end
                n_state = S_WNEXT;
            end
            S_WNEXT: begin
                n_w = r_w + 14'(r_aw);
                n_state = S_WCHK;
            end
            // force mode splits a single-tile axis
            S_FORCE: begin
                if (!r_found) begin
                    n_state = S_DONE;
                end else if (r_cfg_force && r_tcx == 15'd1 && r_tw != 14'(r_aw)) begin
                    div_go = 1'b1;  div_a = DW'((r_tw + 14'd1) >> 1);
                    div_b = DW'(r_aw);  go_ret = S_FX;
                end else begin
                    n_state = S_FY;
                end
            end
            S_FX: begin
                n_tw = q_rup[13:0];  n_tcx = 15'd2;
                n_state = S_FY;
            end
            S_FY: begin
                if (r_cfg_force && r_tcy == 15'd1 && r_th != r_ah) begin
                    div_go = 1'b1;  div_a = DW'((r_th + AHW'(1)) >> 1);
                    div_b = DW'(r_ah);  go_ret = S_FY2;
                end else begin
                    n_state = S_PIPE;
                end
            end
            S_FY2: begin
                n_th = q_rup[AHW-1:0];  n_tcy = 15'd2;
                n_state = S_PIPE;
            end
            // pipe grid
            S_PIPE: begin
                if (r_fdm && r_cfg_merge) begin
                    n_pw = 15'(MERGE_PIPE_W);  n_ph = 15'(MERGE_PIPE_H);
                    n_pcx = m_pcx;  n_pcy = m_pcy;
                    mul_go = 1'b1;  mul_a = MW'(m_pcx);  mul_b = MW'(m_pcy);
                    go_ret = S_MOK;
                end else begin
                    n_pw = 15'd1;  n_ph = 15'd1;  n_pcx = r_tcx;  n_pcy = r_tcy;
                    mul_go = 1'b1;  mul_a = MW'(r_tcx);  mul_b = MW'(r_tcy);
                    go_ret = S_GCHK;
                end
            end
            S_MOK: begin
                n_ok = (r_prod <= 32'(r_limit));
                n_state = S_ON;
            end
            S_GCHK: begin
                if (r_prod > 32'(r_limit)) begin
                    div_go = 1'b1;
                    if (r_pw < r_ph) begin
                        n_pw = r_pw + 15'd1;
                        div_a = DW'(r_tcx);  div_b = DW'(r_pw + 15'd1);  go_ret = S_GX;
                    end else begin
                        n_ph = r_ph + 15'd1;
                        div_a = DW'(r_tcy);  div_b = DW'(r_ph + 15'd1);  go_ret = S_GY;
                    end
                end else begin
                    mul_go = 1'b1;  mul_a = MW'(r_pw);  mul_b = MW'(r_ph);  go_ret = S_GOK;
                end
            end
            S_GX: begin
                n_pcx = q_ceil[14:0];
                mul_go = 1'b1;  mul_a = MW'(q_ceil[14:0]);  mul_b = MW'(r_pcy);
                go_ret = S_GCHK;
            end
            S_GY: begin
                n_pcy = q_ceil[14:0];
                mul_go = 1'b1;  mul_a = MW'(r_pcx);  mul_b = MW'(q_ceil[14:0]);
                go_ret = S_GCHK;
            end
            S_GOK: begin
                n_ok = (r_prod <= 32'(PIPE_TILE_MAX));
                n_state = S_ON;
            end
            // binning decision
            S_ON: begin
                if (r_ok) begin
                    mul_go = 1'b1;  mul_a = MW'(r_tcx);  mul_b = MW'(r_tcy);  go_ret = S_ON2;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ON2: begin
                n_on = ((r_prod > 32'd2) || r_cfg_force) && !r_cfg_dis;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // launch the shared units
        if (div_go) begin
            n_dvd = div_a;  n_dvs = div_b;  n_quo = div_a;  n_rem = '0;
            n_cnt = '0;  n_ret = go_ret;  n_state = S_DIV;
        end
        if (mul_go) begin
            n_ma = mul_a;  n_mb = mul_b;  n_ret = go_ret;  n_state = S_MUL;
        end
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_aw    <= 11'd32;
            r_cfg_ah    <= 11'd16;
            r_cfg_mtw   <= 13'd1024;
            r_cfg_mth   <= 13'd1008;
            r_cfg_lim   <= 6'd32;
            r_cfg_force <= 1'b0;
            r_cfg_dis   <= 1'b0;
            r_cfg_merge <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_ALIGN_W:  r_cfg_aw    <= i_cfg_data[10:0];
                    REG_ALIGN_H:  r_cfg_ah    <= i_cfg_data[10:0];
                    REG_MAX_TW:   r_cfg_mtw   <= i_cfg_data;
                    REG_MAX_TH:   r_cfg_mth   <= i_cfg_data;
                    REG_PIPE_LIM: r_cfg_lim   <= i_cfg_data[5:0];
                    REG_FORCE:    r_cfg_force <= i_cfg_data[0];
                    REG_DISABLE:  r_cfg_dis   <= i_cfg_data[0];
                    REG_MERGE:    r_cfg_merge <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;  r_cnt <= n_cnt;
        r_fw <= n_fw;  r_fh <= n_fh;  r_layers <= n_layers;  r_budget <= n_budget;
        r_fdm <= n_fdm;  r_aw <= n_aw;  r_ah <= n_ah;  r_limit <= n_limit;
        r_maxw <= n_maxw;  r_maxh <= n_maxh;  r_w <= n_w;  r_h <= n_h;  r_hc <= n_hc;
        r_cx <= n_cx;  r_cy <= n_cy;  r_tw <= n_tw;  r_th <= n_th;
        r_tcx <= n_tcx;  r_tcy <= n_tcy;  r_best <= n_best;  r_bdiff <= n_bdiff;
        r_found <= n_found;  r_ok <= n_ok;  r_on <= n_on;
        r_pw <= n_pw;  r_ph <= n_ph;  r_pcx <= n_pcx;  r_pcy <= n_pcy;
        r_dvd <= n_dvd;  r_dvs <= n_dvs;  r_quo <= n_quo;  r_rem <= n_rem;
        r_ma <= n_ma;  r_mb <= n_mb;
        r_prod <= r_ma * r_mb;
    end

    // Result item
    assign o_done         = (r_state == S_DONE);
    assign o_possible     = r_found;
    assign o_tile_width   = r_tw[12:0];
    assign o_tile_height  = r_th[12:0];
    assign o_tiles_x      = r_tcx;
    assign o_tiles_y      = r_tcy;
    assign o_pipe_tiles_x = r_pw;
    assign o_pipe_tiles_y = r_ph;
    assign o_pipes_x      = r_pcx;
    assign o_pipes_y      = r_pcy;
    assign o_binning_ok   = r_ok;
    assign o_binning_on   = r_on;

`ifndef SYNTHESIS
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_acc |=> busy) else $error("accepted item did not raise busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy) else $error("sequencer not idle after result");
    a_div_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dvs != '0)) else $error("division by zero");
    a_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!r_on || (r_ok && r_found))) else $error("binning on without ok");
    a_found_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_tcx != '0 && r_tcy != '0 && r_pw != '0 && r_ph != '0))
        else $error("zero tile or pipe count");
`endif

endmodule

// File: tb/sv/tb_tile_bin_layout_planner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tile_bin_layout_planner
// Self-checking bench for the tile/bin layout planner. Requests are driven
// through the start/busy port and each o_done strobe is compared with the
// plan computed by a behavioral planner kept in the bench. The register file
// is rewritten between phases (resets, extremes, random settings) while the
// block is idle, and the request rate is varied per phase.
// ----------------------------------------------------------------------------
module tb_tile_bin_layout_planner
    import tblp_pkg::*;
();

    localparam int  WATCHDOG_LIMIT = 4000000;
    localparam int  DRAIN_CYCLES   = 64;

    typedef struct {
        logic        possible;
        logic [12:0] tile_width;
        logic [12:0] tile_height;
        logic [14:0] tiles_x;
        logic [14:0] tiles_y;
        logic [14:0] pipe_tiles_x;
        logic [14:0] pipe_tiles_y;
        logic [14:0] pipes_x;
        logic [14:0] pipes_y;
        logic        binning_ok;
        logic        binning_on;
    } plan_t;

    typedef struct {
        logic [14:0] fw;
        logic [14:0] fh;
        logic [11:0] layers;
        logic [5:0]  views;
        logic [6:0]  cpp;
        logic [23:0] budget;
        logic        fdm;
    } request_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [14:0] i_frame_width = '0;
    logic [14:0] i_frame_height = '0;
    logic [11:0] i_frame_layers = '0;
    logic [5:0]  i_view_count = '0;
    logic [6:0]  i_min_bytes_per_pixel = '0;
    logic [23:0] i_budget_pixels = '0;
    logic        i_density_map = 1'b0;
    logic        o_done;
    logic        o_possible;
    logic [12:0] o_tile_width;
    logic [12:0] o_tile_height;
    logic [14:0] o_tiles_x;
    logic [14:0] o_tiles_y;
    logic [14:0] o_pipe_tiles_x;
    logic [14:0] o_pipe_tiles_y;
    logic [14:0] o_pipes_x;
    logic [14:0] o_pipes_y;
    logic        o_binning_ok;
    logic        o_binning_on;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data = '0;

    // Bench copy of the register file
    logic [10:0] cfg_align_w;
    logic [10:0] cfg_align_h;
    logic [12:0] cfg_max_tw;
    logic [12:0] cfg_max_th;
    logic [5:0]  cfg_pipe_lim;
    logic        cfg_force;
    logic        cfg_disable;
    logic        cfg_merge;

    plan_t       pending_plans[$];
    int          error_count = 0;
    int          idle_pct = 0;
    int          quiet_cycles = 0;

    tile_bin_layout_planner dut (.*);

    always #2 i_clk = ~i_clk;

    // Behavioral planner
    function automatic longint unsigned cdiv(longint unsigned a, longint unsigned b);
        return (a + b - 1) / b;
    endfunction

    function automatic longint unsigned rup(longint unsigned v, longint unsigned g);
        return cdiv(v, g) * g;
    endfunction

    function automatic longint unsigned adiff(longint unsigned a, longint unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic plan_t plan_layout(request_t r);
        longint unsigned aw, ah, lim, lyr, stride, maxw, maxh, w, h, cx, cy, best;
        longint unsigned tw, th, tcx, tcy, pw, ph, pcx, pcy, ok, on;
        int              tz;
        bit              found;
        plan_t           p;
        aw    = (cfg_align_w != 0) ? cfg_align_w : 1;
        ah    = (cfg_align_h != 0) ? cfg_align_h : 1;
        lim   = (cfg_pipe_lim != 0) ? cfg_pipe_lim : 1;
        lyr   = (r.layers > r.views) ? r.layers : r.views;
        best  = '1;
        tw = 0; th = 0; tcx = 1; tcy = 1;
        pw = 1; ph = 1; pcx = 1; pcy = 1; ok = 0; on = 0;
        found = 0;
        if (lyr == 0) lyr = 1;

        // Widen the height granularity so one layer is stride aligned
        stride = ah * aw * r.cpp;
        if (lyr > 1 && (stride & ((64'd1 << STRIDE_ALIGN_LOG2) - 1)) != 0) begin
            tz = 0;
            while (((stride >> tz) & 1) == 0) tz++;
            ah = ah << (STRIDE_ALIGN_LOG2 - tz);
        end

        // Width search: fewest bins, then squarest
        if (r.budget != 0) begin
            maxw = (cfg_max_tw < rup(r.fw, aw)) ? cfg_max_tw : rup(r.fw, aw);
            maxh = (cfg_max_th < rup(r.fh, ah)) ? cfg_max_th : rup(r.fh, ah);
            for (w = aw; w <= maxw; w += aw) begin
                h = r.budget / (w * lyr);
                if (h > maxh) h = maxh;
                h = (h / ah) * ah;
                if (h != 0) begin
                    cx = cdiv(r.fw, w);
                    cy = cdiv(r.fh, h);
                    h  = rup(cdiv(r.fh, cy), ah);
                    if (cx * cy < best ||
                        (cx * cy == best && adiff(w, h) < adiff(tw, th))) begin
                        found = 1;
                        tw = w; th = h; tcx = cx; tcy = cy;
                        best = cx * cy;
                    end
                end
            end
        end

        // Force mode splits single-tile axes
        if (found && cfg_force) begin
            if (tcx == 1 && tw != aw) begin
                tw = rup(cdiv(tw, 2), aw);
                tcx = 2;
            end
            if (tcy == 1 && th != ah) begin
                th = rup(cdiv(th, 2), ah);
                tcy = 2;
            end
        end

        // Pipe grid and binning decision
        if (found) begin
            if (r.fdm && cfg_merge) begin
                pw  = MERGE_PIPE_W;
                ph  = MERGE_PIPE_H;
                pcx = cdiv(tcx, pw);
                pcy = cdiv(tcy, ph);
                ok  = (pcx * pcy <= lim);
            end else begin
                pcx = tcx;
                pcy = tcy;
                while (pcx * pcy > lim) begin
                    if (pw < ph) begin
                        pw++;
                        pcx = cdiv(tcx, pw);
                    end else begin
                        ph++;
                        pcy = cdiv(tcy, ph);
                    end
                end
                ok = (pw * ph <= PIPE_TILE_MAX);
            end
            if (ok != 0) begin
                on = (tcx * tcy > 2);
                if (cfg_force) on = 1;
                if (cfg_disable) on = 0;
            end
        end

        p.possible     = found;
        p.tile_width   = tw[12:0];
        p.tile_height  = th[12:0];
        p.tiles_x      = tcx[14:0];
        p.tiles_y      = tcy[14:0];
        p.pipe_tiles_x = pw[14:0];
        p.pipe_tiles_y = ph[14:0];
        p.pipes_x      = pcx[14:0];
        p.pipes_y      = pcy[14:0];
        p.binning_ok   = ok[0];
        p.binning_on   = on[0];
        return p;
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        plan_t e;
        if (i_rst_n && o_done) begin
            if (pending_plans.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                e = pending_plans.pop_front();
                if (o_possible !== e.possible) begin
                    $error("possible exp %0d got %0d", e.possible, o_possible);
                    error_count++;
                end
                if (o_tile_width !== e.tile_width) begin
                    $error("tile_width exp %0d got %0d", e.tile_width, o_tile_width);
                    error_count++;
                end
                if (o_tile_height !== e.tile_height) begin
                    $error("tile_height exp %0d got %0d", e.tile_height, o_tile_height);
                    error_count++;
                end
                if (o_tiles_x !== e.tiles_x) begin
                    $error("tiles_x exp %0d got %0d", e.tiles_x, o_tiles_x);
                    error_count++;
                end
                if (o_tiles_y !== e.tiles_y) begin
                    $error("tiles_y exp %0d got %0d", e.tiles_y, o_tiles_y);
                    error_count++;
                end
                if (o_pipe_tiles_x !== e.pipe_tiles_x) begin
                    $error("pipe_tiles_x exp %0d got %0d", e.pipe_tiles_x, o_pipe_tiles_x);
                    error_count++;
                end
                if (o_pipe_tiles_y !== e.pipe_tiles_y) begin
                    $error("pipe_tiles_y exp %0d got %0d", e.pipe_tiles_y, o_pipe_tiles_y);
                    error_count++;
                end
                if (o_pipes_x !== e.pipes_x) begin
                    $error("pipes_x exp %0d got %0d", e.pipes_x, o_pipes_x);
                    error_count++;
                end
                if (o_pipes_y !== e.pipes_y) begin
                    $error("pipes_y exp %0d got %0d", e.pipes_y, o_pipes_y);
                    error_count++;
                end
                if (o_binning_ok !== e.binning_ok) begin
                    $error("binning_ok exp %0d got %0d", e.binning_ok, o_binning_ok);
                    error_count++;
                end
                if (o_binning_on !== e.binning_on) begin
                    $error("binning_on exp %0d got %0d", e.binning_on, o_binning_on);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: cycles with no item accepted and no result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_tile_bin_layout_planner NOT OK");
                $finish;
            end
        end
    end

    // Send one request; called at a falling edge, returns at a falling edge
    task automatic send_request(request_t r);
        int gap;
        i_frame_width         = r.fw;
        i_frame_height        = r.fh;
        i_frame_layers        = r.layers;
        i_view_count          = r.views;
        i_min_bytes_per_pixel = r.cpp;
        i_budget_pixels       = r.budget;
        i_density_map         = r.fdm;
        start                 = 1'b1;
        do @(posedge i_clk); while (busy);
        pending_plans.push_back(plan_layout(r));
        @(negedge i_clk);
        start = 1'b0;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 40);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Register write, only while idle
    task automatic write_reg(logic [2:0] idx, logic [12:0] val);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_ALIGN_W:  cfg_align_w  = val[10:0];
            REG_ALIGN_H:  cfg_align_h  = val[10:0];
            REG_MAX_TW:   cfg_max_tw   = val;
            REG_MAX_TH:   cfg_max_th   = val;
            REG_PIPE_LIM: cfg_pipe_lim = val[5:0];
            REG_FORCE:    cfg_force    = val[0];
            REG_DISABLE:  cfg_disable  = val[0];
            default:      cfg_merge    = val[0];
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_plans.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_all(int aw, int ah, int mtw, int mth, int lim,
                               int frc, int dis, int mrg);
        wait_idle();
        write_reg(REG_ALIGN_W, 13'(aw));
        write_reg(REG_ALIGN_H, 13'(ah));
        write_reg(REG_MAX_TW, 13'(mtw));
        write_reg(REG_MAX_TH, 13'(mth));
        write_reg(REG_PIPE_LIM, 13'(lim));
        write_reg(REG_FORCE, 13'(frc));
        write_reg(REG_DISABLE, 13'(dis));
        write_reg(REG_MERGE, 13'(mrg));
    endtask

    function automatic request_t mk(int fw, int fh, int lyr, int vw, int cpp,
                                    int bud, int fdm);
        request_t r;
        r.fw = 15'(fw); r.fh = 15'(fh); r.layers = 12'(lyr); r.views = 6'(vw);
        r.cpp = 7'(cpp); r.budget = 24'(bud); r.fdm = fdm[0];
        return r;
    endfunction

    // Directed: reset settings, field extremes, not-possible paths
    task automatic test_reset_settings();
        send_request(mk(1920, 1080, 1, 0, 4, 200000, 0));
        send_request(mk(1920, 1080, 1, 0, 4, 0, 0));
        send_request(mk(16384, 16384, 1, 0, 1, 24'hFFFFFF, 0));
        send_request(mk(1, 1, 1, 0, 64, 1, 0));
        send_request(mk(0, 100, 1, 0, 4, 100000, 0));
        send_request(mk(640, 480, 2048, 0, 3, 24'hFFFFFF, 0));
        send_request(mk(640, 480, 0, 0, 4, 500000, 0));
        send_request(mk(640, 480, 1, 32, 4, 500000, 1));
        send_request(mk(800, 600, 4, 0, 0, 300000, 0));
        send_request(mk(256, 256, 1, 0, 4, 65536, 1));
    endtask

    // Directed: register extremes, force/disable/merge combinations
    task automatic test_register_extremes();
        program_all(1, 1, 1, 1, 1, 1, 0, 1);
        send_request(mk(5, 7, 1, 0, 4, 100, 1));
        send_request(mk(5, 7, 3, 0, 5, 100000, 0));
        send_request(mk(1, 1, 1, 0, 1, 1, 0));
        program_all(1024, 1024, 4096, 4096, 32, 0, 1, 1);
        send_request(mk(16384, 16384, 1, 0, 1, 24'hFFFFFF, 1));
        send_request(mk(16384, 16384, 1, 0, 1, 24'hFFFFFF, 0));
        send_request(mk(3000, 50, 1, 0, 2, 24'hFFFFFF, 0));
        program_all(0, 0, 0, 0, 0, 0, 0, 0);
        send_request(mk(10, 10, 1, 0, 4, 1000, 0));
        program_all(0, 0, 64, 64, 0, 1, 1, 0);
        send_request(mk(3, 3, 2, 0, 3, 50, 0));
        send_request(mk(40, 40, 1, 0, 4, 200, 0));
        program_all(24, 12, 96, 1008, 3, 1, 0, 1);
        send_request(mk(96, 900, 1, 0, 4, 24'hFFFFFF, 0));
        send_request(mk(60, 5000, 1, 0, 4, 3000, 1));
        send_request(mk(60, 600, 1, 0, 4, 3000, 0));
        program_all(32, 16, 1024, 1008, 32, 1, 0, 0);
        send_request(mk(64, 32, 1, 0, 4, 24'hFFFFFF, 0));
        send_request(mk(32, 16, 1, 0, 4, 24'hFFFFFF, 0));
    endtask

    // Random requests sized so only a few widths are tried per item
    function automatic request_t random_request();
        request_t r;
        int       awe, fw;
        awe = (cfg_align_w != 0) ? cfg_align_w : 1;
        fw  = $urandom_range(1, awe * $urandom_range(1, 5));
        if (fw > 16384) fw = 16384;
        if ($urandom_range(99) < 2) fw = 0;
        r.fw     = 15'(fw);
        r.fh     = 15'($urandom_range(99) < 3 ? $urandom_range(0, 16384)
                                              : $urandom_range(1, 300));
        r.layers = ($urandom_range(1) != 0) ? 12'd1
                 : 12'($urandom_range(0, 2048) >> $urandom_range(0, 11));
        r.views  = ($urandom_range(99) < 30) ? 6'($urandom_range(0, 32)) : 6'd0;
        r.cpp    = ($urandom_range(99) < 3) ? 7'd0 : 7'($urandom_range(1, 64));
        r.budget = ($urandom_range(99) < 8) ? 24'd0
                 : 24'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 20));
        r.fdm    = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic test_random_settings(int phases, int per_phase);
        int ph, n, mode;
        for (ph = 0; ph < phases; ph++) begin
            program_all($urandom_range(0, 1024), $urandom_range(0, 1024),
                        $urandom_range(0, 4096), $urandom_range(0, 4096),
                        $urandom_range(1, 32), $urandom_range(1),
                        int'($urandom_range(3) == 0), $urandom_range(1));
            mode = ph % 4;
            idle_pct = (mode == 0) ? 0 : (mode == 1) ? 85 : (mode == 2) ? 0 : 32;
            for (n = 0; n < per_phase; n++) send_request(random_request());
        end
    endtask

    initial begin
        cfg_align_w = 11'd32; cfg_align_h = 11'd16;
        cfg_max_tw = 13'd1024; cfg_max_th = 13'd1008; cfg_pipe_lim = 6'd32;
        cfg_force = 1'b0; cfg_disable = 1'b0; cfg_merge = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_settings();
        test_register_extremes();
        test_random_settings(10, 82);

        wait_idle();
        if (error_count == 0) begin
            $display("tb_tile_bin_layout_planner OK");
        end else begin
            $display("tb_tile_bin_layout_planner NOT OK");
        end
        $finish;
    end

endmodule
